>>> hw/rtl/ssc_pkg.sv
// shared types, constants and helpers for the subrip structure checker
// no dependencies

package ssc_pkg;

    localparam int LINE_LIMIT = 256;
    localparam int COUNT_BITS = 20;
    localparam int LINE_BITS  = $clog2(LINE_LIMIT + 1);
    localparam int TEXT_BITS  = 16;
    localparam int ARROW_LEN  = 5;
    localparam int ARROW_BITS = $clog2(ARROW_LEN + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] KIND_NUMBER = 3'd0;
    localparam logic [2:0] KIND_TIME   = 3'd1;
    localparam logic [2:0] KIND_TEXT   = 3'd2;
    localparam logic [2:0] KIND_SEP    = 3'd3;
    localparam logic [2:0] KIND_BLANK  = 3'd4;
    localparam logic [2:0] KIND_END    = 3'd5;

    localparam logic [3:0] ERR_OK       = 4'd0;
    localparam logic [3:0] ERR_TOO_LONG = 4'd1;
    localparam logic [3:0] ERR_STRAY    = 4'd2;
    localparam logic [3:0] ERR_BAD_NUM  = 4'd3;
    localparam logic [3:0] ERR_NO_TIME  = 4'd4;
    localparam logic [3:0] ERR_BAD_TIME = 4'd5;
    localparam logic [3:0] ERR_UNCLOSED = 4'd6;
    localparam logic [3:0] ERR_EMPTY    = 4'd7;
    localparam logic [3:0] ERR_TOO_MANY = 4'd8;

    typedef enum logic [1:0] {
        MODE_START,
        MODE_TIME,
        MODE_TEXT,
        MODE_AFTER
    } mode_t;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_TRAIL,
        PH_BAD
    } phase_t;

    typedef struct packed {
        mode_t                  mode;
        logic [LINE_BITS-1:0]   line_bytes;
        phase_t                 phase;
        logic [ARROW_BITS-1:0]  arrow;
        logic                   zero_seen;
        logic [COUNT_BITS-1:0]  subtitles;
        logic [TEXT_BITS-1:0]   text_count;
        logic                   last_blank;
        logic                   any_seen;
        logic [3:0]             sticky;
    } parse_state_t;

    localparam parse_state_t ST_RESET = '{
        mode:       MODE_START,
        line_bytes: '0,
        phase:      PH_LEAD,
        arrow:      '0,
        zero_seen:  1'b0,
        subtitles:  '0,
        text_count: '0,
        last_blank: 1'b0,
        any_seen:   1'b0,
        sticky:     ERR_OK
    };

    typedef struct packed {
        logic [2:0]            line_kind;
        logic [COUNT_BITS-1:0] subtitle_index;
        logic [TEXT_BITS-1:0]  text_lines;
        logic [7:0]            line_length;
        logic [3:0]            error_code;
        logic                  done_res;
    } result_t;

    function automatic logic [7:0] arrow_char(input logic [ARROW_BITS-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            ARROW_BITS'(0): ch = CH_SPACE;
            ARROW_BITS'(1): ch = CH_DASH;
            ARROW_BITS'(2): ch = CH_DASH;
            ARROW_BITS'(3): ch = CH_GT;
            default:        ch = CH_SPACE;
        endcase
        return ch;
    endfunction

endpackage

>>> hw/rtl/ssc_in_if.sv
// input channel: one file word or end of file with valid/ready
// no dependencies

interface ssc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

>>> hw/rtl/ssc_out_if.sv
// result channel: one checked line or end summary with valid/ready
// depends on ssc_pkg

interface ssc_out_if
    import ssc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [2:0]            line_kind;
    logic [COUNT_BITS-1:0] subtitle_index;
    logic [TEXT_BITS-1:0]  text_lines;
    logic [7:0]            line_length;
    logic [3:0]            error_code;
    logic                  done_res;

    modport source (
        output valid, output line_kind, output subtitle_index, output text_lines,
        output line_length, output error_code, output done_res, input ready
    );
    modport sink (
        input valid, input line_kind, input subtitle_index, input text_lines,
        input line_length, input error_code, input done_res, output ready
    );
endinterface

>>> hw/rtl/subrip_structure_checker.sv
// subrip structure checker top level: input register, line evaluation, result register
// depends on ssc_pkg, ssc_in_if, ssc_out_if and ssc_line_eval
//
// usage
//   item_in carries one file word per handshake (op 0) or end of file (op 1)
//   item_out carries one result per completed line and one summary at end of file
//   carriage returns and ordinary bytes give no result, line feeds and end of file do
//   a word is taken every cycle while the result side keeps up: one word per cycle
// a word passes through the input register, and its result is written to the
//   result register, from which item_out offers it
//   the input register holds one word; a word that makes no result moves on even
//     while the result register is stalled
//   when item_out.ready is low the result holds, and the input register stops
//     only once it holds a word that makes a result; then item_in.ready drops
//   reset clears parser state, counts and sticky error, and empties both registers
//   after the end of file summary the parser returns to its reset state by itself
//   the first error code stays in every later result until that point

module subrip_structure_checker
    import ssc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ssc_in_if.sink   item_in,
    ssc_out_if.source item_out
);

    logic         s1_valid_reg;
    logic         s1_valid_next;
    logic         s1_op_reg;
    logic [7:0]   s1_byte_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      out_res_reg;

    logic         has_result;
    result_t      res;
    logic         s1_fire;
    logic         in_fire;

    ssc_line_eval u_eval (
        .cur        (state_reg),
        .op         (s1_op_reg),
        .data_byte  (s1_byte_reg),
        .nxt        (state_next),
        .has_result (has_result),
        .res        (res)
    );

    assign s1_fire = s1_valid_reg && (!has_result || !out_valid_reg || item_out.ready);
    assign item_in.ready = !s1_valid_reg || s1_fire;
    assign in_fire = item_in.valid && item_in.ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = (s1_fire && has_result) ? 1'b1
                          : (item_out.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg   <= item_in.op;
            s1_byte_reg <= item_in.data_byte;
        end
        if (s1_fire && has_result)
            out_res_reg <= res;
    end

    assign item_out.valid          = out_valid_reg;
    assign item_out.line_kind      = out_res_reg.line_kind;
    assign item_out.subtitle_index = out_res_reg.subtitle_index;
    assign item_out.text_lines     = out_res_reg.text_lines;
    assign item_out.line_length    = out_res_reg.line_length;
    assign item_out.error_code     = out_res_reg.error_code;
    assign item_out.done_res       = out_res_reg.done_res;

endmodule

>>> hw/rtl/ssc_line_eval.sv
// next parser state and optional result for one word against the current state
// depends on ssc_pkg

module ssc_line_eval
    import ssc_pkg::*;
(
    input  parse_state_t cur,
    input  logic         op,
    input  logic [7:0]   data_byte,
    output parse_state_t nxt,
    output logic         has_result,
    output result_t      res
);

    parse_state_t          closed;
    parse_state_t          eof_st;
    logic                  by_lf;
    logic                  blank;
    logic                  overlong;
    logic [3:0]            err;
    logic [2:0]            kind;
    logic [3:0]            eof_err;
    logic                  is_blank;
    logic                  is_digit;
    logic [LINE_BITS+7:0]  len_ext;
    logic [7:0]            len_sat;

    assign by_lf    = !op;
    assign is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign len_ext  = (LINE_BITS + 8)'(cur.line_bytes);
    assign len_sat  = (len_ext > (LINE_BITS + 8)'(255)) ? 8'hFF : len_ext[7:0];

    // line close
    always_comb
    begin
        closed   = cur;
        closed.any_seen = 1'b1;
        err      = ERR_OK;
        kind     = KIND_BLANK;
        blank    = by_lf && (cur.line_bytes == '0);
        overlong = by_lf ? (cur.line_bytes >= LINE_BITS'(LINE_LIMIT - 1))
                         : (cur.line_bytes >= LINE_BITS'(LINE_LIMIT));
        if (blank)
        begin
            unique case (cur.mode)
                MODE_TEXT:
                begin
                    kind        = KIND_SEP;
                    closed.mode = MODE_AFTER;
                end
                MODE_AFTER: closed.last_blank = 1'b1;
                MODE_TIME:  err = ERR_NO_TIME;
                default:    err = ERR_STRAY;
            endcase
        end
        else if (cur.mode == MODE_TIME)
        begin
            kind = KIND_TIME;
            if (cur.arrow == ARROW_BITS'(ARROW_LEN))
                closed.mode = MODE_TEXT;
            else
                err = ERR_BAD_TIME;
        end
        else if (cur.mode == MODE_TEXT)
        begin
            kind = KIND_TEXT;
            if (cur.text_count != '1)
                closed.text_count = cur.text_count + 1'b1;
        end
        else
        begin
            kind = KIND_NUMBER;
            priority if (cur.last_blank)
                err = ERR_STRAY;
            else if (cur.phase != PH_DIGITS && cur.phase != PH_TRAIL)
                err = ERR_BAD_NUM;
            else if (&cur.subtitles)
                err = ERR_TOO_MANY;
            else
            begin
                closed.subtitles  = cur.subtitles + 1'b1;
                closed.text_count = '0;
                closed.mode       = MODE_TIME;
            end
        end
        if (err == ERR_OK && overlong)
            err = ERR_TOO_LONG;
        if (cur.sticky == ERR_OK)
            closed.sticky = err;
        closed.line_bytes = '0;
        closed.phase      = PH_LEAD;
        closed.arrow      = '0;
        closed.zero_seen  = 1'b0;
    end

    // end of file summary
    always_comb
    begin
        eof_st  = (cur.line_bytes != '0) ? closed : cur;
        eof_err = eof_st.sticky;
        if (eof_st.sticky == ERR_OK)
        begin
            priority if (!eof_st.any_seen)
                eof_err = ERR_EMPTY;
            else if (eof_st.mode == MODE_TIME || eof_st.mode == MODE_TEXT)
                eof_err = ERR_UNCLOSED;
        end
    end

    always_comb
    begin
        nxt        = cur;
        has_result = 1'b0;
        res        = '0;
        if (op)
        begin
            has_result         = 1'b1;
            res.line_kind      = KIND_END;
            res.subtitle_index = eof_st.subtitles;
            res.text_lines     = eof_st.text_count;
            res.line_length    = '0;
            res.error_code     = eof_err;
            res.done_res       = 1'b1;
            nxt                = ST_RESET;
        end
        else if (data_byte == CH_CR)
        begin
            nxt = cur;
        end
        else if (data_byte == CH_LF)
        begin
            nxt                = closed;
            has_result         = 1'b1;
            res.line_kind      = kind;
            res.subtitle_index = closed.subtitles;
            res.text_lines     = closed.text_count;
            res.line_length    = len_sat;
            res.error_code     = closed.sticky;
            res.done_res       = 1'b0;
        end
        else
        begin
            if (cur.line_bytes < LINE_BITS'(LINE_LIMIT))
                nxt.line_bytes = cur.line_bytes + 1'b1;
            if (!cur.zero_seen)
            begin
                if (data_byte == CH_NUL)
                begin
                    nxt.zero_seen = 1'b1;
                end
                else
                begin
                    unique case (cur.phase)
                        PH_LEAD:
                            nxt.phase = is_blank ? PH_LEAD : (is_digit ? PH_DIGITS : PH_BAD);
                        PH_DIGITS:
                            nxt.phase = is_digit ? PH_DIGITS : (is_blank ? PH_TRAIL : PH_BAD);
                        PH_TRAIL:
                            nxt.phase = is_blank ? PH_TRAIL : PH_BAD;
                        default:
                            nxt.phase = PH_BAD;
                    endcase
                    if (cur.arrow < ARROW_BITS'(ARROW_LEN))
                    begin
                        if (data_byte == arrow_char(cur.arrow))
                            nxt.arrow = cur.arrow + 1'b1;
                        else
                            nxt.arrow = (data_byte == CH_SPACE) ? ARROW_BITS'(1) : '0;
                    end
                end
            end
        end
    end

endmodule
